// ----- rtl/core/psd3_pkg.sv -----
// Shared constants, codes and types for the point to segment distance block.
`timescale 1ns / 1ps
`default_nettype none

package psd3_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_Z   = 3'd5;

  localparam logic [1:0] CODE_INTERIOR = 2'd0;
  localparam logic [1:0] CODE_START    = 2'd1;
  localparam logic [1:0] CODE_END      = 2'd2;
  localparam logic [1:0] CODE_DEGEN    = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
    logic [2:0] dneg;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/psd3_div.sv -----
// Pipelined three-lane restoring divider with a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module psd3_div #(
  parameter int W   = psd3_pkg::COORD_WIDTH,
  parameter int SBW = 3 * W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire psd3_pkg::ctl_t       ctl_in,
  input  wire logic [SBW-1:0]       sb_in,
  input  wire logic [3*W+3:0]       num [3],
  input  wire logic [2*W+2:0]       den,
  output psd3_pkg::ctl_t            ctl_out,
  output logic [SBW-1:0]            sb_out,
  output logic [W-1:0]              quo [3]
);

  localparam int DENW = 2 * W + 3;

  logic [DENW-1:0]  rem  [W][3];
  logic [W-1:0]     nq   [W][3];
  logic [DENW-1:0]  dens [W];
  psd3_pkg::ctl_t   cq   [W];
  logic [SBW-1:0]   sq   [W];

  genvar j, i;
  generate
    for (j = 0; j < W; j++) begin : g_stage
      logic [DENW-1:0] rem_in [3];
      logic [W-1:0]    nq_in  [3];
      logic [DENW-1:0] den_in;
      psd3_pkg::ctl_t  ctl_i;
      logic [SBW-1:0]  sb_i;

      if (j == 0) begin : g_first
        always_comb begin
          for (int k = 0; k < 3; k++) begin
            rem_in[k] = num[k][W+DENW-1:W];
            nq_in[k]  = num[k][W-1:0];
          end
          den_in = den;
          ctl_i  = ctl_in;
          sb_i   = sb_in;
        end
      end else begin : g_next
        always_comb begin
          for (int k = 0; k < 3; k++) begin
            rem_in[k] = rem[j-1][k];
            nq_in[k]  = nq[j-1][k];
          end
          den_in = dens[j-1];
          ctl_i  = cq[j-1];
          sb_i   = sq[j-1];
        end
      end

      for (i = 0; i < 3; i++) begin : g_lane
        logic [DENW:0] rs;
        logic [DENW:0] diff;
        logic          ge;
        always_comb begin
          rs   = {rem_in[i], nq_in[i][W-1]};
          ge   = (rs >= {1'b0, den_in});
          diff = rs - {1'b0, den_in};
        end
        always_ff @(posedge clk) begin
          if (en) begin
            rem[j][i] <= ge ? diff[DENW-1:0] : rs[DENW-1:0];
            nq[j][i]  <= {nq_in[i][W-2:0], ge};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          cq[j] <= '0;
        end else if (en) begin
          cq[j] <= ctl_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dens[j] <= den_in;
          sq[j]   <= sb_i;
        end
      end
    end
  endgenerate

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo[k] = nq[W-1][k];
    end
  end

  assign ctl_out = cq[W-1];
  assign sb_out  = sq[W-1];

endmodule

`default_nettype wire

// ----- rtl/core/psd3_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module psd3_sqrt #(
  parameter int W   = psd3_pkg::COORD_WIDTH,
  parameter int SBW = 3 * W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire psd3_pkg::ctl_t       ctl_in,
  input  wire logic [SBW-1:0]       sb_in,
  input  wire logic [2*W+1:0]       rad_in,
  output psd3_pkg::ctl_t            ctl_out,
  output logic [SBW-1:0]            sb_out,
  output logic [W:0]                root_out
);

  localparam int RW  = W + 1;
  localparam int SQW = 2 * RW;

  logic [RW:0]     rem  [RW];
  logic [RW-1:0]   root [RW];
  logic [SQW-1:0]  rad  [RW];
  psd3_pkg::ctl_t  cq   [RW];
  logic [SBW-1:0]  sq   [RW];

  genvar j;
  generate
    for (j = 0; j < RW; j++) begin : g_stage
      logic [RW:0]    rem_i;
      logic [RW-1:0]  root_i;
      logic [SQW-1:0] rad_i;
      psd3_pkg::ctl_t ctl_i;
      logic [SBW-1:0] sb_i;
      logic [RW+2:0]  rs;
      logic [RW+2:0]  trial;
      logic [RW+2:0]  diff;
      logic           ge;

      if (j == 0) begin : g_first
        always_comb begin
          rem_i  = '0;
          root_i = '0;
          rad_i  = rad_in;
          ctl_i  = ctl_in;
          sb_i   = sb_in;
        end
      end else begin : g_next
        always_comb begin
          rem_i  = rem[j-1];
          root_i = root[j-1];
          rad_i  = rad[j-1];
          ctl_i  = cq[j-1];
          sb_i   = sq[j-1];
        end
      end

      always_comb begin
        rs    = {rem_i, rad_i[SQW-1:SQW-2]};
        trial = {1'b0, root_i, 2'b01};
        ge    = (rs >= trial);
        diff  = rs - trial;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          cq[j] <= '0;
        end else if (en) begin
          cq[j] <= ctl_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j]  <= ge ? diff[RW:0] : rs[RW:0];
          root[j] <= {root_i[RW-2:0], ge};
          rad[j]  <= {rad_i[SQW-3:0], 2'b00};
          sq[j]   <= sb_i;
        end
      end
    end
  endgenerate

  assign ctl_out  = cq[RW-1];
  assign sb_out   = sq[RW-1];
  assign root_out = root[RW-1];

endmodule

`default_nettype wire

// ----- rtl/core/point_segment_distance_3d.sv -----
// Top level: nearest point on a 3D segment and the distance to it, fully pipelined.
// Throughput is one word per cycle while the output skid entry is empty; the quotient and root
// pipelines retire one bit per stage. A one-entry output skid register holds a stalled output
// word, so the pipeline still advances in the cycle in which the output stalls.
// Reset clears the segment registers, all valid bits and the output skid entry.
`timescale 1ns / 1ps
`default_nettype none

module point_segment_distance_3d #(
  parameter int W = psd3_pkg::COORD_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // point_x, point_y, point_z, zero fill
  input  wire logic [((3*W+7)/8)*8-1:0]              s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // near_x, near_y, near_z, distance, clamp_code, zero fill
  output logic [((4*W+10)/8)*8-1:0]                  m_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [psd3_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [W-1:0]                          cfg_data
);

  localparam int DW   = W + 1;
  localparam int LW   = 2 * W + 2;
  localparam int TW   = 2 * W + 3;
  localparam int HW   = W + 1;
  localparam int NW   = 3 * W + 4;
  localparam int DENW = 2 * W + 3;
  localparam int RW   = W + 1;
  localparam int SQW  = 2 * W + 2;
  localparam int OUTW = ((4 * W + 10) / 8) * 8;

  logic signed [W-1:0] seg_start [3];
  logic signed [W-1:0] seg_end   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        seg_start[k] <= '0;
        seg_end[k]   <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        psd3_pkg::REG_START_X: seg_start[0] <= cfg_data;
        psd3_pkg::REG_START_Y: seg_start[1] <= cfg_data;
        psd3_pkg::REG_START_Z: seg_start[2] <= cfg_data;
        psd3_pkg::REG_END_X:   seg_end[0]   <= cfg_data;
        psd3_pkg::REG_END_Y:   seg_end[1]   <= cfg_data;
        psd3_pkg::REG_END_Z:   seg_end[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_full;
  logic [OUTW-1:0] skid_data;

  assign en       = !skid_full;
  assign s_tready = en;

  logic signed [W-1:0] p_in [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_in[k] = s_tdata[k*W +: W];
    end
  end

  logic                 v1, v2, v3;
  logic signed [DW-1:0] d1 [3], d2 [3], d3 [3];
  logic signed [DW-1:0] vv1 [3];
  logic signed [W-1:0]  p1 [3], p2 [3], p3 [3], p4 [3], p5 [3];
  logic signed [2*DW-1:0] dd2 [3], dv2 [3];
  logic [LW-1:0]        l3, l4, l5;
  logic signed [TW-1:0] t3;
  logic [LW-1:0]        tu4;
  logic [W-1:0]         ad4 [3];
  logic [W-1:0]         ad_c [3];
  logic [DW-1:0]        dabs_c [3];
  logic [2*W:0]         pl5 [3], ph5 [3];
  logic [NW-1:0]        num6 [3];
  logic [DENW-1:0]      den6;
  logic [3*W-1:0]       pk6;
  psd3_pkg::ctl_t       c4, c5, c6;
  psd3_pkg::ctl_t       c4_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      c4 <= c4_next;
      c5 <= c4;
      c6 <= c5;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dabs_c[k] = d3[k][DW-1] ? DW'(-d3[k]) : DW'(d3[k]);
      ad_c[k]   = dabs_c[k][W-1:0];
    end
    c4_next.valid = v3;
    c4_next.dneg  = {d3[2][DW-1], d3[1][DW-1], d3[0][DW-1]};
    if (l3 == '0) begin
      c4_next.code = psd3_pkg::CODE_DEGEN;
    end else if (t3[TW-1]) begin
      c4_next.code = psd3_pkg::CODE_START;
    end else if (t3 > $signed({1'b0, l3})) begin
      c4_next.code = psd3_pkg::CODE_END;
    end else begin
      c4_next.code = psd3_pkg::CODE_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1[k]  <= DW'(seg_end[k]) - DW'(seg_start[k]);
        vv1[k] <= DW'(p_in[k]) - DW'(seg_start[k]);
        p1[k]  <= p_in[k];
        dd2[k] <= d1[k] * d1[k];
        dv2[k] <= d1[k] * vv1[k];
        d2[k]  <= d1[k];
        p2[k]  <= p1[k];
        d3[k]  <= d2[k];
        p3[k]  <= p2[k];
        ad4[k] <= ad_c[k];
        p4[k]  <= p3[k];
        pl5[k] <= ad4[k] * tu4[HW-1:0];
        ph5[k] <= ad4[k] * tu4[LW-1:HW];
        p5[k]  <= p4[k];
        num6[k] <= NW'({({ph5[k], {HW{1'b0}}} + NW'(pl5[k])), 1'b0}) + NW'(l5);
        pk6[k*W +: W] <= p5[k];
      end
      l3   <= LW'(dd2[0]) + LW'(dd2[1]) + LW'(dd2[2]);
      t3   <= TW'(dv2[0]) + TW'(dv2[1]) + TW'(dv2[2]);
      l4   <= l3;
      tu4  <= t3[LW-1:0];
      l5   <= l4;
      den6 <= {l5, 1'b0};
    end
  end

  psd3_pkg::ctl_t cd;
  logic [3*W-1:0] pkd;
  logic [W-1:0]   quo [3];

  psd3_div #(
    .W   (W),
    .SBW (3 * W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (c6),
    .sb_in   (pk6),
    .num     (num6),
    .den     (den6),
    .ctl_out (cd),
    .sb_out  (pkd),
    .quo     (quo)
  );

  psd3_pkg::ctl_t       ce1, ce2, ce3, ce4;
  logic signed [W-1:0]  near_c [3];
  logic signed [DW-1:0] adj_c [3];
  logic signed [W-1:0]  near1 [3], near2 [3], near3 [3];
  logic signed [W-1:0]  pe1 [3];
  logic signed [DW-1:0] df2 [3];
  logic [2*DW-1:0]      sq3 [3];
  logic [SQW-1:0]       dist2;
  logic [3*W-1:0]       pk4;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      adj_c[k] = DW'(seg_start[k]) +
                 (cd.dneg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]}));
      case (cd.code)
        psd3_pkg::CODE_INTERIOR: near_c[k] = adj_c[k][W-1:0];
        psd3_pkg::CODE_END:      near_c[k] = seg_end[k];
        default:                 near_c[k] = seg_start[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ce1 <= '0;
      ce2 <= '0;
      ce3 <= '0;
      ce4 <= '0;
    end else if (en) begin
      ce1 <= cd;
      ce2 <= ce1;
      ce3 <= ce2;
      ce4 <= ce3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        near1[k] <= near_c[k];
        pe1[k]   <= pkd[k*W +: W];
        df2[k]   <= DW'(pe1[k]) - DW'(near1[k]);
        near2[k] <= near1[k];
        sq3[k]   <= df2[k] * df2[k];
        near3[k] <= near2[k];
        pk4[k*W +: W] <= near3[k];
      end
      dist2 <= SQW'(sq3[0] + sq3[1] + sq3[2]);
    end
  end

  psd3_pkg::ctl_t cs;
  logic [3*W-1:0] pks;
  logic [RW-1:0]  root;

  psd3_sqrt #(
    .W   (W),
    .SBW (3 * W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ce4),
    .sb_in    (pk4),
    .rad_in   (dist2),
    .ctl_out  (cs),
    .sb_out   (pks),
    .root_out (root)
  );

  logic [OUTW-1:0] out_word;
  assign out_word = OUTW'({cs.code, root, pks});

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_tready) begin
        skid_full <= 1'b0;
      end
    end else if (cs.valid && !m_tready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_data <= out_word;
    end
  end

  assign m_tvalid = skid_full || cs.valid;
  assign m_tdata  = skid_full ? skid_data : out_word;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output word valid right after reset.");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (cs.valid && !skid_full && !m_tready) |=> skid_full)
    else $error("Stalled output word was not caught by the skid entry.");

  a_interior_code: assert property (@(posedge clk) disable iff (rst)
    (en && v3 && !t3[TW-1] && ($signed({1'b0, l3}) >= t3) && (l3 != '0))
      |=> (c4.code == psd3_pkg::CODE_INTERIOR))
    else $error("Projection inside the segment not flagged as interior.");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the point to segment distance block.
`timescale 1ns / 1ps

module testbench;

  localparam int W = psd3_pkg::COORD_WIDTH;
  localparam int IW = psd3_pkg::CFG_INDEX_WIDTH;
  localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W:0] DIST_MAX = {(W+1){1'b1}};
  localparam int PHASES = 10;
  localparam int PHASE_POINTS = 155;

  typedef struct packed {
    logic signed [W-1:0] near_x;
    logic signed [W-1:0] near_y;
    logic signed [W-1:0] near_z;
    logic [W:0] distance;
    logic [1:0] code;
  } nearest_t;

  typedef struct packed {
    logic [5:0][W-1:0] seg;
    logic [2:0][W-1:0] pt;
    logic known;
    nearest_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [((3*W+7)/8)*8-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((4*W+10)/8)*8-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  logic signed [W-1:0] seg_cfg [6];
  nearest_t nearest_q[$];
  dir_row_t dir_rows[$];
  int errors = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  point_segment_distance_3d dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic nearest_t predict_nearest(input logic signed [W-1:0] px,
                                               input logic signed [W-1:0] py,
                                               input logic signed [W-1:0] pz);
    logic signed [159:0] sv[3], ev[3], pv[3], dv[3], nv[3];
    logic signed [159:0] len2, dot, num, q, dist2, diff, root, trial;
    nearest_t r;
    len2 = 0;
    dot = 0;
    pv[0] = px;
    pv[1] = py;
    pv[2] = pz;
    for (int i = 0; i < 3; i++) begin
      sv[i] = seg_cfg[i];
      ev[i] = seg_cfg[i+3];
      dv[i] = ev[i] - sv[i];
      len2 = len2 + dv[i] * dv[i];
      dot = dot + dv[i] * (pv[i] - sv[i]);
    end
    if (len2 == 0) begin
      r.code = psd3_pkg::CODE_DEGEN;
      nv = sv;
    end else if (dot < 0) begin
      r.code = psd3_pkg::CODE_START;
      nv = sv;
    end else if (dot > len2) begin
      r.code = psd3_pkg::CODE_END;
      nv = ev;
    end else begin
      r.code = psd3_pkg::CODE_INTERIOR;
      for (int i = 0; i < 3; i++) begin
        num = 2 * (dv[i] < 0 ? -dv[i] : dv[i]) * dot + len2;
        q = num / (2 * len2);
        nv[i] = sv[i] + (dv[i] < 0 ? -q : q);
      end
    end
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      diff = pv[i] - nv[i];
      dist2 = dist2 + diff * diff;
    end
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      if (trial * trial <= dist2) root = trial;
    end
    if (root > DIST_MAX) root = DIST_MAX;
    r.near_x = nv[0][W-1:0];
    r.near_y = nv[1][W-1:0];
    r.near_z = nv[2][W-1:0];
    r.distance = root[W:0];
    return r;
  endfunction

  function automatic logic [5:0][W-1:0] mk_seg(input logic [W-1:0] sx, sy, sz, ex, ey, ez);
    return {ez, ey, ex, sz, sy, sx};
  endfunction

  function automatic nearest_t mk_res(input logic [W-1:0] nx, ny, nz,
                                      input logic [W:0] dist_val, input logic [1:0] code);
    nearest_t r;
    r.near_x = nx;
    r.near_y = ny;
    r.near_z = nz;
    r.distance = dist_val;
    r.code = code;
    return r;
  endfunction

  task automatic add_row(input logic [5:0][W-1:0] seg_v, input logic [2:0][W-1:0] pt_v,
                         input logic known_v, input nearest_t res_v);
    dir_row_t row;
    row.seg = seg_v;
    row.pt = pt_v;
    row.known = known_v;
    row.res = res_v;
    dir_rows = {dir_rows, row};
  endtask

  task automatic report(input string what, input logic [W:0] got, input logic [W:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    nearest_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = mk_res(m_tdata[W-1:0], m_tdata[2*W-1:W], m_tdata[3*W-1:2*W],
                   m_tdata[4*W:3*W], m_tdata[4*W+2:4*W+1]);
      if (nearest_q.size() == 0) begin
        report("unexpected word", '0, '0);
      end else begin
        want = nearest_q.pop_front();
        if (got.near_x !== want.near_x) report("near_x", got.near_x, want.near_x);
        if (got.near_y !== want.near_y) report("near_y", got.near_y, want.near_y);
        if (got.near_z !== want.near_z) report("near_z", got.near_z, want.near_z);
        if (got.distance !== want.distance) report("distance", got.distance, want.distance);
        if (got.code !== want.code) report("clamp_code", got.code, want.code);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic write_reg(input logic [IW-1:0] idx, input logic [W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= psd3_pkg::REG_END_Z) seg_cfg[idx] = val;
  endtask

  task automatic drain;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_segment(input logic [5:0][W-1:0] seg);
    drain();
    for (int i = 0; i < 6; i++) write_reg(IW'(psd3_pkg::REG_START_X + i), seg[i]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(input logic [W-1:0] px, py, pz,
                            input bit known, input nearest_t res);
    nearest_t want_v;
    s_tvalid <= 1'b1;
    s_tdata <= {pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want_v = known ? res : predict_nearest(px, py, pz);
    nearest_q = {nearest_q, want_v};
    if (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [W-1:0] rand_coord;
    case ($urandom_range(5))
      0: return $urandom_range(1) ? CMIN : CMAX;
      1, 2: return W'(signed'($urandom_range(2_000_000)) - 1_000_000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] near_coord(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [W+1:0] v;
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? CMIN : CMAX;
      default: begin
        v = ($urandom_range(1) ? a : b) + (signed'($urandom_range(4_000_000)) - 2_000_000);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v[W-1:0];
      end
    endcase
  endfunction

  initial begin
    logic [5:0][W-1:0] cur_seg, seg;
    logic [W-1:0] pxv, pyv, pzv;
    for (int i = 0; i < 6; i++) seg_cfg[i] = '0;
    cur_seg = '0;

    add_row('0, {32'd0, 32'd0, 32'd0}, 1'b1,
            mk_res(0, 0, 0, 0, psd3_pkg::CODE_DEGEN));
    add_row('0, {32'd0, 32'd0, CMIN}, 1'b1,
            mk_res(0, 0, 0, 33'h0_8000_0000, psd3_pkg::CODE_DEGEN));
    add_row(mk_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), {CMIN, CMIN, CMIN}, 1'b0, '0);
    seg = mk_seg(0, 0, 0, 655360, 0, 0);
    add_row(seg, {32'd0, 32'd0, -32'sd65536}, 1'b1,
            mk_res(0, 0, 0, 65536, psd3_pkg::CODE_START));
    add_row(seg, {32'd0, 32'd0, 32'd720896}, 1'b1,
            mk_res(655360, 0, 0, 65536, psd3_pkg::CODE_END));
    add_row(seg, {32'd0, 32'd65536, 32'd327680}, 1'b1,
            mk_res(327680, 0, 0, 65536, psd3_pkg::CODE_INTERIOR));
    add_row(seg, {32'd0, 32'd131072, 32'd0}, 1'b1,
            mk_res(0, 0, 0, 131072, psd3_pkg::CODE_INTERIOR));
    add_row(seg, {32'd0, -32'sd131072, 32'd655360}, 1'b1,
            mk_res(655360, 0, 0, 131072, psd3_pkg::CODE_INTERIOR));
    add_row(mk_seg(0, 0, 0, 3, 1, 0), {32'd0, 32'd2, 32'd1}, 1'b0, '0);
    add_row(mk_seg(0, 0, 0, -3, -1, 0), {32'd0, -32'sd2, -32'sd1}, 1'b0, '0);
    seg = mk_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_row(seg, {32'd0, CMIN, CMAX}, 1'b0, '0);
    add_row(seg, {CMAX, CMAX, CMIN}, 1'b0, '0);
    add_row(seg, {CMAX, CMAX, CMAX}, 1'b0, '0);
    seg = mk_seg(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    add_row(seg, {32'd0, 32'd0, 32'd0}, 1'b0, '0);
    add_row(seg, {CMAX, CMAX, CMAX}, 1'b0, '0);
    add_row(seg, {CMIN, CMIN, CMIN}, 1'b0, '0);
    add_row(mk_seg(0, 0, CMIN, 0, 0, CMAX), {32'd0, CMAX, CMAX}, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Writes to unused indexes must leave the segment untouched.
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].seg != cur_seg) begin
        s_tvalid <= 1'b0;
        cur_seg = dir_rows[k].seg;
        load_segment(cur_seg);
      end
      send_point(dir_rows[k].pt[0], dir_rows[k].pt[1], dir_rows[k].pt[2],
                 dir_rows[k].known, dir_rows[k].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      s_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        seg[i] = rand_coord();
        seg[i+3] = rand_coord();
      end
      if (ph % 4 == 3) for (int i = 0; i < 3; i++) seg[i+3] = seg[i];
      load_segment(seg);
      calm = (ph == 2);
      if (ph == 4) hold_left = 400;
      for (int n = 0; n < PHASE_POINTS; n++) begin
        pxv = near_coord(seg_cfg[0], seg_cfg[3]);
        pyv = near_coord(seg_cfg[1], seg_cfg[4]);
        pzv = near_coord(seg_cfg[2], seg_cfg[5]);
        send_point(pxv, pyv, pzv, 1'b0, '0);
      end
      calm = 1'b0;
    end
    s_tvalid <= 1'b0;

    while (nearest_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
